// ----- rtl/soe_pkg.sv -----
`default_nettype none
package soe_pkg;
	localparam int SLOT_COUNT_DEF = 256;
	localparam int MAX_IW = 12;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_KILL  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	typedef struct packed {
		logic              shift;
		logic              tick;
		logic              kill;
		logic              clear;
		logic              write;
		logic [MAX_IW-1:0] sel;
		logic [15:0]       span;
	} cell_ctrl_t;
endpackage
`default_nettype wire

// ----- rtl/soe_cell.sv -----
`default_nettype none
module soe_cell #(
	parameter int IDX = 0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire soe_pkg::cell_ctrl_t ctrl,
	input  wire  [15:0]             nxt,
	output logic [15:0]             life
);
	import soe_pkg::*;

	logic [15:0] life_q;
	logic        hit;

	assign hit  = (ctrl.sel == MAX_IW'(IDX));
	assign life = life_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= '0;
		end else if (ctrl.clear) begin
			life_q <= '0;
		end else if (ctrl.shift) begin
			life_q <= nxt;
		end else if (ctrl.tick) begin
			if (life_q != 16'd0) begin
				life_q <= life_q - 16'd1;
			end
		end else if (ctrl.kill && hit) begin
			life_q <= '0;
		end else if (ctrl.write && hit) begin
			life_q <= ctrl.span;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/slot_allocator_oldest_eviction.sv -----
// Slot allocator with oldest-slot eviction.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low; req_type selects allocate, tick, kill or clear, with life_span and
// target_slot as operands. Every transaction returns exactly one result on
// granted_slot/evicted, marked by done for one cycle. The receiver cannot stall.
// Tick, kill and clear act in the accepting cycle: done follows in the next cycle.
// Allocate rotates the row of slot cells once around past the head cell,
// examining one slot per cycle in the scan state, then writes the chosen slot
// in the write state, after which done is shown. busy is high from accept
// until the write cycle ends; a new transaction may be accepted in the cycle
// done is shown.
// Reset clears every slot to free and the search pointer to zero at once.
`default_nettype none
module slot_allocator_oldest_eviction #(
	parameter int SLOT_COUNT = soe_pkg::SLOT_COUNT_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  req_type,
	input  wire  [15:0] life_span,
	input  wire  [7:0]  target_slot,
	output logic        done,
	output logic [7:0]  granted_slot,
	output logic        evicted
);
	import soe_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] cnt_q, ptr_q, hi_q, lo_q, midx_q;
	logic          fhi_q, flo_q;
	logic [15:0]   minv_q, span_q;
	logic          done_q, evicted_q;
	logic [7:0]    granted_q;

	logic [15:0]   life [SLOT_COUNT];
	cell_ctrl_t    ctrl;
	logic          accept, head_free;
	logic [IW-1:0] chosen;
	logic [MAX_IW-1:0] chosen_w;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign head_free = (life[0] == 16'd0);
	assign chosen    = fhi_q ? hi_q : (flo_q ? lo_q : midx_q);
	assign chosen_w  = MAX_IW'(chosen);

	always_comb begin
		ctrl       = '0;
		ctrl.shift = (state_q == ST_SCAN);
		ctrl.span  = span_q;
		if (state_q == ST_WRITE) begin
			ctrl.write = 1'b1;
			ctrl.sel   = chosen_w;
		end else if (accept) begin
			ctrl.tick  = (req_type == REQ_TICK);
			ctrl.kill  = (req_type == REQ_KILL);
			ctrl.clear = (req_type == REQ_CLEAR);
			ctrl.sel   = MAX_IW'(target_slot);
		end
	end

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		soe_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.nxt    (life[(i + 1) % SLOT_COUNT]),
			.life   (life[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ptr_q   <= '0;
			fhi_q   <= 1'b0;
			flo_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == REQ_ALLOC) begin
							state_q <= ST_SCAN;
							cnt_q   <= '0;
							fhi_q   <= 1'b0;
							flo_q   <= 1'b0;
						end else begin
							done_q <= 1'b1;
							if (req_type == REQ_CLEAR) begin
								ptr_q <= '0;
							end
						end
					end
				end
				ST_SCAN: begin
					if (head_free && (cnt_q >= ptr_q) && !fhi_q) begin
						fhi_q <= 1'b1;
					end
					if (head_free && !flo_q) begin
						flo_q <= 1'b1;
					end
					if (cnt_q == LAST) begin
						state_q <= ST_WRITE;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					ptr_q   <= (chosen == LAST) ? '0 : chosen + IW'(1);
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			span_q    <= life_span;
			granted_q <= '0;
			evicted_q <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			if (head_free && (cnt_q >= ptr_q) && !fhi_q) begin
				hi_q <= cnt_q;
			end
			if (head_free && !flo_q) begin
				lo_q <= cnt_q;
			end
			if ((cnt_q == '0) || (life[0] < minv_q)) begin
				minv_q <= life[0];
				midx_q <= cnt_q;
			end
		end
		if (state_q == ST_WRITE) begin
			granted_q <= chosen_w[7:0];
			evicted_q <= !fhi_q && !flo_q;
		end
	end

	assign done         = done_q;
	assign granted_slot = granted_q;
	assign evicted      = done_q && evicted_q;

	a_evict_done: assert property (@(posedge clk) disable iff (!arst_n)
		evicted |-> done)
		else $error("evicted without done");
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cnt_q == LAST) |=> (state_q == ST_WRITE))
		else $error("scan did not end in write");
	a_other_req: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type != REQ_ALLOC) |=> (done && !evicted && granted_slot == 8'd0))
		else $error("non-allocate result wrong");
	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> (done && !busy))
		else $error("write not followed by done");
endmodule
`default_nettype wire
